>>> rtl/core/rsos_pkg.sv
`default_nettype none

package rsos_pkg;

   localparam int DEPTH = 32;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = 4;

   typedef struct packed {
      logic signed [7:0]  in_layer;
      logic signed [15:0] in_y;
      logic [7:0]         in_tag;
      logic               in_last;
   } req_type;

   typedef struct packed {
      logic signed [7:0]  out_layer;
      logic signed [15:0] out_y;
      logic [7:0]         out_tag;
      logic               out_last;
      logic               dropped;
   } rsp_type;

   typedef struct packed {
      logic signed [7:0]  layer;
      logic signed [15:0] y;
      logic [7:0]         tag;
   } rec_type;

   localparam logic [2:0] CND_NONE    = 3'd0;
   localparam logic [2:0] CND_ALWAYS  = 3'd1;
   localparam logic [2:0] CND_WAIT    = 3'd2;
   localparam logic [2:0] CND_SHORT   = 3'd3;
   localparam logic [2:0] CND_BOUNDS  = 3'd4;
   localparam logic [2:0] CND_NOTEND  = 3'd5;
   localparam logic [2:0] CND_MORE    = 3'd6;
   localparam logic [2:0] CND_MOREOUT = 3'd7;

   localparam logic [1:0] RA_ZERO  = 2'd0;
   localparam logic [1:0] RA_START = 2'd1;
   localparam logic [1:0] RA_STEP1 = 2'd2;
   localparam logic [1:0] RA_STEP2 = 2'd3;

   localparam logic [1:0] IX_HOLD  = 2'd0;
   localparam logic [1:0] IX_ZERO  = 2'd1;
   localparam logic [1:0] IX_START = 2'd2;
   localparam logic [1:0] IX_STEP  = 2'd3;

   localparam logic [1:0] CY_HOLD = 2'd0;
   localparam logic [1:0] CY_LOAD = 2'd1;
   localparam logic [1:0] CY_CMP  = 2'd2;

   localparam logic [1:0] WE_NONE  = 2'd0;
   localparam logic [1:0] WE_CMP   = 2'd1;
   localparam logic [1:0] WE_CARRY = 2'd2;

   typedef struct packed {
      logic [2:0]    cond;
      logic [SW-1:0] target;
      logic [1:0]    ra_sel;
      logic [1:0]    ix_sel;
      logic          dir_up;
      logic [1:0]    cy_op;
      logic [1:0]    we_op;
      logic          ld_en;
      logic          bnd_init;
      logic          bnd_pass;
      logic          swp_clr;
      logic          emit;
      logic          done;
   } ctl_type;

   typedef struct packed {
      logic last_load;
      logic short_batch;
      logic bounds_done;
      logic not_end;
      logic more;
      logic more_out;
   } cond_type;

   // Flipping the sign bits turns the signed (layer, y) pair into one unsigned key.
   function automatic logic [23:0] rec_key(input rec_type r);
      return {~r.layer[7], r.layer[6:0], ~r.y[15], r.y[14:0]};
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/rsos_seq.sv
`default_nettype none

module rsos_seq (
   input  logic               clock,
   input  logic               reset,
   input  rsos_pkg::cond_type cond,
   output rsos_pkg::ctl_type  ctl
);
   import rsos_pkg::*;

   localparam logic [SW-1:0] ST_IDLE   = 4'd0;
   localparam logic [SW-1:0] ST_SETUP  = 4'd1;
   localparam logic [SW-1:0] ST_PSTART = 4'd2;
   localparam logic [SW-1:0] ST_CARRY  = 4'd3;
   localparam logic [SW-1:0] ST_CMP    = 4'd4;
   localparam logic [SW-1:0] ST_FLUSH  = 4'd5;
   localparam logic [SW-1:0] ST_EMIT0  = 4'd6;
   localparam logic [SW-1:0] ST_EMIT   = 4'd7;
   localparam logic [SW-1:0] ST_DONE   = 4'd8;

   logic [SW-1:0] step_ff;
   logic [SW-1:0] step_in;
   logic          jump;

   function automatic ctl_type rom(input logic [SW-1:0] s);
      ctl_type w;
      w = '0;
      case (s)
         ST_IDLE: begin
            w.ld_en  = 1'b1;
            w.cond   = CND_WAIT;
            w.target = ST_IDLE;
         end
         ST_SETUP: begin
            w.bnd_init = 1'b1;
            w.cond     = CND_SHORT;
            w.target   = ST_EMIT0;
         end
         ST_PSTART: begin
            w.cond    = CND_BOUNDS;
            w.target  = ST_EMIT0;
            w.ra_sel  = RA_START;
            w.ix_sel  = IX_START;
            w.swp_clr = 1'b1;
         end
         ST_CARRY: begin
            w.cy_op  = CY_LOAD;
            w.ra_sel = RA_STEP1;
         end
         ST_CMP: begin
            w.we_op  = WE_CMP;
            w.cy_op  = CY_CMP;
            w.ix_sel = IX_STEP;
            w.ra_sel = RA_STEP2;
            w.cond   = CND_NOTEND;
            w.target = ST_CMP;
         end
         ST_FLUSH: begin
            w.we_op    = WE_CARRY;
            w.bnd_pass = 1'b1;
            w.cond     = CND_MORE;
            w.target   = ST_PSTART;
         end
         ST_EMIT0: begin
            w.ix_sel = IX_ZERO;
            w.ra_sel = RA_ZERO;
         end
         ST_EMIT: begin
            w.emit   = 1'b1;
            w.ix_sel = IX_STEP;
            w.dir_up = 1'b1;
            w.ra_sel = RA_STEP1;
            w.cond   = CND_MOREOUT;
            w.target = ST_EMIT;
         end
         ST_DONE: begin
            w.done   = 1'b1;
            w.cond   = CND_ALWAYS;
            w.target = ST_IDLE;
         end
         default: begin
            w.cond   = CND_ALWAYS;
            w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

   always_comb begin
      ctl = rom(step_ff);
   end

   always_comb begin
      case (ctl.cond)
         CND_NONE:    jump = 1'b0;
         CND_ALWAYS:  jump = 1'b1;
         CND_WAIT:    jump = ~cond.last_load;
         CND_SHORT:   jump = cond.short_batch;
         CND_BOUNDS:  jump = cond.bounds_done;
         CND_NOTEND:  jump = cond.not_end;
         CND_MORE:    jump = cond.more;
         CND_MOREOUT: jump = cond.more_out;
         default:     jump = 1'b1;
      endcase
      step_in = jump ? ctl.target : step_ff + SW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/render_order_shaker_sort_top.sv
// Channel   Ports                                   Transfer
// request   start, busy, req_data                   beat when start and not busy
// response  rsp_valid, rsp_data                     beat on every cycle rsp_valid is high
// config    psel, penable, pwrite, paddr, pwdata,   write when psel, penable, pwrite
//           prdata, pready                          and pready are high
//
// Records load at one per cycle while the block is idle.
// After the last record of a batch comes a setup state; each pass then runs a start state,
// a carry load, one compare per record pair and a flush, paced by the registered store read.
// Reset is synchronous and returns the block to idle with an empty batch.
// The receiver cannot stall; each result beat is shown for exactly one cycle.
`default_nettype none

module render_order_shaker_sort_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rsos_pkg::req_type req_data,
   output logic              rsp_valid,
   output rsos_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import rsos_pkg::*;

   localparam logic REG_FULL_SORT = 1'b0;

   ctl_type  ctl;
   cond_type cond;

   rec_type store_ff [DEPTH];
   rec_type rd_ff;
   rec_type carry_ff, carry_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] lo_ff, lo_in;
   logic [AW-1:0] hi_ff, hi_in;
   logic [CW-1:0] count_ff, count_in;
   logic          overflow_ff, overflow_in;
   logic          pass_forward_ff, pass_forward_in;
   logic          swapped_ff, swapped_in;
   logic          full_sort_ff, full_sort_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   logic          load;
   logic          fwd;
   logic [AW-1:0] idx_p1, idx_p2, start_ptr, end_ptr, raddr, waddr;
   logic          we;
   rec_type       wdata;
   logic          swap;
   logic          last_out;
   logic          csr_write;

   rsos_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctl   (ctl)
   );

   assign busy   = ~ctl.ld_en;
   assign load   = start & ctl.ld_en;
   assign pready = 1'b1;

   always_comb begin
      fwd       = ctl.dir_up | pass_forward_ff;
      idx_p1    = fwd ? idx_ff + AW'(1) : idx_ff - AW'(1);
      idx_p2    = fwd ? idx_ff + AW'(2) : idx_ff - AW'(2);
      start_ptr = pass_forward_ff ? lo_ff : hi_ff;
      end_ptr   = pass_forward_ff ? hi_ff : lo_ff;
      last_out  = (CW'(idx_ff) == count_ff - CW'(1));
      if (pass_forward_ff) begin
         swap = rec_key(carry_ff) > rec_key(rd_ff);
      end else begin
         swap = rec_key(carry_ff) < rec_key(rd_ff);
      end

      case (ctl.ra_sel)
         RA_ZERO:  raddr = '0;
         RA_START: raddr = start_ptr;
         RA_STEP1: raddr = idx_p1;
         RA_STEP2: raddr = idx_p2;
         default:  raddr = '0;
      endcase

      we    = 1'b0;
      waddr = idx_ff;
      wdata = carry_ff;
      if (load && (count_ff < CW'(DEPTH))) begin
         we    = 1'b1;
         waddr = count_ff[AW-1:0];
         wdata = '{layer: req_data.in_layer, y: req_data.in_y, tag: req_data.in_tag};
      end else begin
         case (ctl.we_op)
            WE_CMP: begin
               we    = 1'b1;
               wdata = swap ? rd_ff : carry_ff;
            end
            WE_CARRY: begin
               we = 1'b1;
            end
            default: begin
               we = 1'b0;
            end
         endcase
      end

      case (ctl.ix_sel)
         IX_HOLD:  idx_in = idx_ff;
         IX_ZERO:  idx_in = '0;
         IX_START: idx_in = start_ptr;
         IX_STEP:  idx_in = idx_p1;
         default:  idx_in = idx_ff;
      endcase

      case (ctl.cy_op)
         CY_LOAD: carry_in = rd_ff;
         CY_CMP:  carry_in = swap ? carry_ff : rd_ff;
         default: carry_in = carry_ff;
      endcase

      swapped_in = swapped_ff;
      if (ctl.swp_clr) begin
         swapped_in = 1'b0;
      end else if (ctl.we_op == WE_CMP) begin
         swapped_in = swapped_ff | swap;
      end

      lo_in           = lo_ff;
      hi_in           = hi_ff;
      pass_forward_in = pass_forward_ff;
      if (ctl.bnd_init) begin
         lo_in = '0;
         hi_in = AW'(count_ff - CW'(1));
      end else if (ctl.bnd_pass) begin
         pass_forward_in = ~pass_forward_ff;
         if (pass_forward_ff) begin
            hi_in = hi_ff - AW'(1);
         end else begin
            lo_in = lo_ff + AW'(1);
         end
      end

      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (ctl.done) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (load) begin
         if (count_ff < CW'(DEPTH)) begin
            count_in = count_ff + CW'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end

      csr_write    = psel & penable & pwrite & (paddr[2] == REG_FULL_SORT);
      full_sort_in = csr_write ? pwdata[0] : full_sort_ff;
      prdata       = (paddr[2] == REG_FULL_SORT) ? 32'(full_sort_ff) : '0;

      cond.last_load   = load & req_data.in_last;
      cond.short_batch = count_ff < CW'(2);
      cond.bounds_done = lo_ff >= hi_ff;
      cond.not_end     = idx_p1 != end_ptr;
      cond.more        = full_sort_ff & swapped_ff;
      cond.more_out    = ~last_out;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rd_ff    <= store_ff[raddr];
      carry_ff <= carry_in;
      idx_ff   <= idx_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      swapped_ff <= swapped_in;
      rsp_data_ff <= '{out_layer: rd_ff.layer, out_y: rd_ff.y, out_tag: rd_ff.tag,
                       out_last: last_out, dropped: overflow_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         overflow_ff     <= 1'b0;
         pass_forward_ff <= 1'b0;
         full_sort_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         count_ff        <= count_in;
         overflow_ff     <= overflow_in;
         pass_forward_ff <= pass_forward_in;
         full_sort_ff    <= full_sort_in;
         rsp_valid_ff    <= ctl.emit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("record count beyond capacity");

   a_bounds: assert property (@(posedge clock) disable iff (reset)
      (ctl.we_op != WE_NONE) |-> (lo_ff <= hi_ff))
      else $error("pass bounds crossed during a store write");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_last) |=> !rsp_valid)
      else $error("result beat after the last of a batch");

endmodule

`default_nettype wire

>>> tb/render_order_shaker_sort_top_tb.sv
`timescale 1ns / 100ps

module render_order_shaker_sort_top_tb;
   import rsos_pkg::*;

   localparam logic [2:0] FULL_SORT_ADDR = 3'd0;
   localparam logic [2:0] SPARE_ADDR = 3'd4;
   localparam int DRAIN_LIMIT = 50000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   render_order_shaker_sort_top dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #2 clock = ~clock;

   // Mirror of the block: the batch being loaded, the pass direction and the mode.
   rec_type batch_store [DEPTH];
   int batch_count = 0;
   bit pass_fwd = 1'b0;
   bit overflow = 1'b0;
   bit full_sort_mode = 1'b0;

   rsp_type sorted_q[$];
   rsp_type want_out;
   req_type plan_rec[$];
   bit plan_typed[$];
   rsp_type plan_want[$];

   int errors = 0;
   int records_sent = 0;
   int batches_sent = 0;
   int results_seen = 0;
   int burst_left = 0;

   function automatic bit sorts_after(rec_type a, rec_type b);
      if ($signed(a.layer) != $signed(b.layer)) begin
         return $signed(a.layer) > $signed(b.layer);
      end
      return $signed(a.y) > $signed(b.y);
   endfunction

   function automatic void shaker_sort(int n);
      int lo;
      int hi;
      bit swapped;
      rec_type t;
      lo = 0;
      hi = n - 1;
      while (lo < hi) begin
         swapped = 1'b0;
         if (pass_fwd) begin
            for (int i = lo; i < hi; i++) begin
               if (sorts_after(batch_store[i], batch_store[i + 1])) begin
                  t = batch_store[i];
                  batch_store[i] = batch_store[i + 1];
                  batch_store[i + 1] = t;
                  swapped = 1'b1;
               end
            end
            pass_fwd = 1'b0;
            hi--;
         end else begin
            for (int i = hi; i > lo; i--) begin
               if (sorts_after(batch_store[i - 1], batch_store[i])) begin
                  t = batch_store[i];
                  batch_store[i] = batch_store[i - 1];
                  batch_store[i - 1] = t;
                  swapped = 1'b1;
               end
            end
            pass_fwd = 1'b1;
            lo++;
         end
         if (!full_sort_mode || !swapped) break;
      end
   endfunction

   task automatic load_record(input req_type r, input bit push_out);
      rsp_type o;
      int n;
      if (batch_count < DEPTH) begin
         batch_store[batch_count] = {r.in_layer, r.in_y, r.in_tag};
         batch_count++;
      end else begin
         overflow = 1'b1;
      end
      if (!r.in_last) return;
      batches_sent++;
      n = batch_count;
      if (n >= 2) shaker_sort(n);
      for (int i = 0; i < n; i++) begin
         o.out_layer = batch_store[i].layer;
         o.out_y = batch_store[i].y;
         o.out_tag = batch_store[i].tag;
         o.out_last = (i == n - 1);
         o.dropped = overflow;
         if (push_out) sorted_q.push_back(o);
      end
      batch_count = 0;
      overflow = 1'b0;
   endtask

   function automatic req_type mk_rec(int layer, int y, int tag, bit last);
      req_type r;
      r.in_layer = layer[7:0];
      r.in_y = y[15:0];
      r.in_tag = tag[7:0];
      r.in_last = last;
      return r;
   endfunction

   function automatic rsp_type mk_out(int layer, int y, int tag, bit last, bit drop);
      rsp_type o;
      o.out_layer = layer[7:0];
      o.out_y = y[15:0];
      o.out_tag = tag[7:0];
      o.out_last = last;
      o.dropped = drop;
      return o;
   endfunction

   task automatic add_row(input req_type r, input bit typed, input rsp_type want);
      plan_rec.push_back(r);
      plan_typed.push_back(typed);
      plan_want.push_back(want);
   endtask

   task automatic check_field(input string name, input logic signed [31:0] exp_v,
                              input logic signed [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (sorted_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_data);
         end else begin
            want_out = sorted_q.pop_front();
            results_seen++;
            check_field("out_layer", $signed(want_out.out_layer), $signed(rsp_data.out_layer));
            check_field("out_y", $signed(want_out.out_y), $signed(rsp_data.out_y));
            check_field("out_tag", {24'd0, want_out.out_tag}, {24'd0, rsp_data.out_tag});
            check_field("out_last", {31'd0, want_out.out_last}, {31'd0, rsp_data.out_last});
            check_field("dropped", {31'd0, want_out.dropped}, {31'd0, rsp_data.dropped});
         end
      end
   end

   // The sender runs in bursts; most bursts end in a short gap, some run straight on.
   task automatic send_rec(input req_type r, input bit typed, input rsp_type want);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      load_record(r, !typed);
      if (typed) sorted_q.push_back(want);
      records_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (sorted_q.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr == FULL_SORT_ADDR) full_sort_mode = data[0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [2:0] addr);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      check_field("full_sort", {31'd0, full_sort_mode}, prdata);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_batch(input int n, input bit narrow);
      int layer;
      int y;
      for (int i = 0; i < n; i++) begin
         if (narrow) begin
            layer = int'($urandom_range(0, 3)) - 2;
            y = int'($urandom_range(0, 4)) - 2;
         end else begin
            layer = $urandom;
            y = $urandom;
         end
         send_rec(mk_rec(layer, y, $urandom_range(0, 255), i == n - 1), 1'b0, '0);
      end
   endtask

   task automatic run_phase(input int target, input int first_size);
      if (first_size > 0) run_batch(first_size, $urandom_range(0, 1));
      while (records_sent < target) begin
         if ($urandom_range(0, 5) == 0) drain();
         run_batch($urandom_range(1, 8), $urandom_range(0, 1));
      end
      drain();
   endtask

   initial begin
      add_row(mk_rec(-128, -32768, 0, 1), 1'b1, mk_out(-128, -32768, 0, 1, 0));
      add_row(mk_rec(127, 32767, 255, 1), 1'b1, mk_out(127, 32767, 255, 1, 0));
      add_row(mk_rec(90, -23131, 165, 1), 1'b1, mk_out(90, -23131, 165, 1, 0));
      add_row(mk_rec(5, 100, 1, 0), 1'b0, '0);
      add_row(mk_rec(-3, 100, 2, 1), 1'b0, '0);
      add_row(mk_rec(2, 7, 10, 0), 1'b0, '0);
      add_row(mk_rec(2, 7, 11, 0), 1'b0, '0);
      add_row(mk_rec(1, 7, 12, 0), 1'b0, '0);
      add_row(mk_rec(2, 7, 13, 1), 1'b0, '0);
      add_row(mk_rec(0, -5, 20, 0), 1'b0, '0);
      add_row(mk_rec(0, 300, 21, 0), 1'b0, '0);
      add_row(mk_rec(0, -32768, 22, 0), 1'b0, '0);
      add_row(mk_rec(0, 32767, 23, 0), 1'b0, '0);
      add_row(mk_rec(0, -5, 24, 1), 1'b0, '0);
      add_row(mk_rec(127, 0, 30, 0), 1'b0, '0);
      add_row(mk_rec(0, 0, 31, 0), 1'b0, '0);
      add_row(mk_rec(-128, 0, 32, 1), 1'b0, '0);
      add_row(mk_rec(-1, -1, 40, 0), 1'b0, '0);
      add_row(mk_rec(-1, 0, 41, 0), 1'b0, '0);
      add_row(mk_rec(0, -1, 42, 1), 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_read(FULL_SORT_ADDR);

      for (int i = 0; i < plan_rec.size(); i++) begin
         send_rec(plan_rec[i], plan_typed[i], plan_want[i]);
      end
      drain();

      csr_write(SPARE_ADDR, 32'h0000_0001);
      csr_read(FULL_SORT_ADDR);
      csr_write(FULL_SORT_ADDR, 32'h0000_0001);
      csr_read(FULL_SORT_ADDR);
      run_phase(records_sent + 35, 0);

      csr_write(FULL_SORT_ADDR, 32'hFFFF_FFFE);
      csr_read(FULL_SORT_ADDR);
      run_phase(records_sent + 40, DEPTH + 2);

      csr_write(FULL_SORT_ADDR, 32'hFFFF_FFFF);
      csr_read(FULL_SORT_ADDR);
      run_phase(records_sent + 40, DEPTH);

      if (sorted_q.size() != 0) begin
         errors++;
         $display("%0t: %0d sorted records never arrived", $time, sorted_q.size());
      end
      $display("Loaded %0d records in %0d batches and checked %0d sorted beats.",
               records_sent, batches_sent, results_seen);
      $display("Covered one-pass and full sorting, an ignored register and an overflowing batch.");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Run timed out.");
      $display("status: fail");
      $finish;
   end

endmodule
